@@ design/ppf_pkg.sv @@
package ppf_pkg;

    localparam int PORT_BITS_DEF = 16;

    localparam logic [7:0] PROTO_TCP  = 8'h06;
    localparam logic [7:0] PROTO_UDP  = 8'h11;
    localparam logic [7:0] PROTO_ICMP = 8'h01;

    // minimum transport header sizes in bytes
    localparam int TCP_MIN_HDR = 20;
    localparam int UDP_HDR     = 8;

    // register select is paddr[2]
    localparam logic REG_FILTER_ENABLE = 1'b0;
    localparam logic REG_ICMP_PASS     = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_INSTALL  = 2'd1,
        CMD_CLASSIFY = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_FILL,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic clear_wr;  // write zero at the sweep counter in all tables
        logic fill_wr;   // write one at the sweep counter in selected tables
        logic load_out;  // load the result register
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;       // command of the held item
        logic no_work;   // install sets nothing
        logic cnt_max;   // sweep counter at last table entry
        logic cnt_at_hi; // sweep counter at end of install range
    } t_sts;

endpackage

@@ design/ppf_flag_ram.sv @@
module ppf_flag_ram #(
    parameter int ADDR_BITS = ppf_pkg::PORT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic                 i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic                 o_rdata
);

    logic r_mem [2**ADDR_BITS];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ppf_ctrl.sv @@
module ppf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  ppf_pkg::t_sts i_sts,
    output ppf_pkg::t_ctl o_ctl
);

    ppf_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppf_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        case (r_state)
            ppf_pkg::ST_INIT: begin
                o_ctl.clear_wr = 1'b1;
                if (i_sts.cnt_max) begin
                    n_state = ppf_pkg::ST_IDLE;
                end
            end
            ppf_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ppf_pkg::ST_DECODE;
                end
            end
            ppf_pkg::ST_DECODE: begin
                case (i_sts.cmd)
                    ppf_pkg::CMD_CLEAR:   n_state = ppf_pkg::ST_CLEAR;
                    ppf_pkg::CMD_INSTALL: begin
                        n_state = i_sts.no_work ? ppf_pkg::ST_DONE : ppf_pkg::ST_FILL;
                    end
                    default:              n_state = ppf_pkg::ST_DONE;
                endcase
            end
            ppf_pkg::ST_CLEAR: begin
                o_ctl.clear_wr = 1'b1;
                if (i_sts.cnt_max) begin
                    n_state = ppf_pkg::ST_DONE;
                end
            end
            ppf_pkg::ST_FILL: begin
                o_ctl.fill_wr = 1'b1;
                if (i_sts.cnt_at_hi) begin
                    n_state = ppf_pkg::ST_DONE;
                end
            end
            ppf_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_ready) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ppf_pkg::ST_IDLE;
                end
            end
            default: n_state = ppf_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ design/ppf_datapath.sv @@
module ppf_datapath #(
    parameter int PORT_BITS = ppf_pkg::PORT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ppf_pkg::t_ctl i_ctl,
    output ppf_pkg::t_sts o_sts,
    input  logic          i_filter_enable,
    input  logic          i_icmp_pass,
    input  logic [1:0]    i_cmd,
    input  logic [7:0]    i_protocol,
    input  logic [5:0]    i_ip_header_len,
    input  logic [15:0]   i_ip_total_len,
    input  logic [3:0]    i_tcp_data_offset,
    input  logic [15:0]   i_port_a,
    input  logic [15:0]   i_port_b,
    input  logic          i_sel_tcp,
    input  logic          i_sel_udp,
    input  logic          i_sel_src,
    input  logic          i_sel_dst,
    output logic          o_pass,
    output logic          o_is_verdict
);

    ppf_pkg::t_cmd        r_cmd;
    logic [7:0]           r_protocol;
    logic [5:0]           r_hlen;
    logic [15:0]          r_tlen;
    logic [3:0]           r_doff;
    logic [PORT_BITS-1:0] r_port_a;
    logic [PORT_BITS-1:0] r_port_b;
    logic                 r_tcp, r_udp, r_src, r_dst;
    logic [PORT_BITS-1:0] r_cnt, n_cnt;
    logic                 r_pass, r_is_verdict;

    logic                 w_we_ts, w_we_td, w_we_us, w_we_ud;
    logic                 w_wdata;
    logic                 w_rd_ts, w_rd_td, w_rd_us, w_rd_ud;
    logic [16:0]          w_tlen, w_min_tcp, w_min_doff, w_min_udp;
    logic                 w_tcp_ok, w_udp_ok, w_verdict;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= ppf_pkg::t_cmd'(i_cmd);
            r_protocol <= i_protocol;
            r_hlen     <= i_ip_header_len;
            r_tlen     <= i_ip_total_len;
            r_doff     <= i_tcp_data_offset;
            r_port_a   <= i_port_a[PORT_BITS-1:0];
            r_port_b   <= i_port_b[PORT_BITS-1:0];
            r_tcp      <= i_sel_tcp;
            r_udp      <= i_sel_udp;
            r_src      <= i_sel_src;
            r_dst      <= i_sel_dst;
        end
        if (i_ctl.load_out) begin
            r_pass       <= (r_cmd == ppf_pkg::CMD_CLASSIFY) && w_verdict;
            r_is_verdict <= (r_cmd == ppf_pkg::CMD_CLASSIFY);
        end
    end

    // sweep counter: starts at zero for clear, at first port for install
    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.load) begin
            n_cnt = (ppf_pkg::t_cmd'(i_cmd) == ppf_pkg::CMD_CLEAR) ?
                    '0 : i_port_a[PORT_BITS-1:0];
        end else if (i_ctl.clear_wr || i_ctl.fill_wr) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign w_wdata = i_ctl.fill_wr;
    assign w_we_ts = i_ctl.clear_wr || (i_ctl.fill_wr && r_tcp && r_src);
    assign w_we_td = i_ctl.clear_wr || (i_ctl.fill_wr && r_tcp && r_dst);
    assign w_we_us = i_ctl.clear_wr || (i_ctl.fill_wr && r_udp && r_src);
    assign w_we_ud = i_ctl.clear_wr || (i_ctl.fill_wr && r_udp && r_dst);

    ppf_flag_ram #(.ADDR_BITS(PORT_BITS)) u_tcp_src (
        .i_clk(i_clk), .i_we(w_we_ts), .i_waddr(r_cnt), .i_wdata(w_wdata),
        .i_raddr(r_port_a), .o_rdata(w_rd_ts)
    );
    ppf_flag_ram #(.ADDR_BITS(PORT_BITS)) u_tcp_dst (
        .i_clk(i_clk), .i_we(w_we_td), .i_waddr(r_cnt), .i_wdata(w_wdata),
        .i_raddr(r_port_b), .o_rdata(w_rd_td)
    );
    ppf_flag_ram #(.ADDR_BITS(PORT_BITS)) u_udp_src (
        .i_clk(i_clk), .i_we(w_we_us), .i_waddr(r_cnt), .i_wdata(w_wdata),
        .i_raddr(r_port_a), .o_rdata(w_rd_us)
    );
    ppf_flag_ram #(.ADDR_BITS(PORT_BITS)) u_udp_dst (
        .i_clk(i_clk), .i_we(w_we_ud), .i_waddr(r_cnt), .i_wdata(w_wdata),
        .i_raddr(r_port_b), .o_rdata(w_rd_ud)
    );

    // length checks
    assign w_tlen     = {1'b0, r_tlen};
    assign w_min_tcp  = {11'd0, r_hlen} + 17'(ppf_pkg::TCP_MIN_HDR);
    assign w_min_doff = {11'd0, r_hlen} + {11'd0, r_doff, 2'b00};
    assign w_min_udp  = {11'd0, r_hlen} + 17'(ppf_pkg::UDP_HDR);
    assign w_tcp_ok   = (w_tlen >= w_min_tcp) && (w_tlen >= w_min_doff);
    assign w_udp_ok   = (w_tlen >= w_min_udp);

    always_comb begin
        if (!i_filter_enable) begin
            w_verdict = 1'b1;
        end else if (r_protocol == ppf_pkg::PROTO_TCP) begin
            w_verdict = w_tcp_ok && (w_rd_ts || w_rd_td);
        end else if (r_protocol == ppf_pkg::PROTO_UDP) begin
            w_verdict = w_udp_ok && (w_rd_us || w_rd_ud);
        end else if (r_protocol == ppf_pkg::PROTO_ICMP) begin
            w_verdict = i_icmp_pass;
        end else begin
            w_verdict = 1'b0;
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.no_work   = (r_port_a > r_port_b) || !(r_tcp || r_udp) || !(r_src || r_dst);
    assign o_sts.cnt_max   = &r_cnt;
    assign o_sts.cnt_at_hi = (r_cnt == r_port_b);

    assign o_pass       = r_pass;
    assign o_is_verdict = r_is_verdict;

endmodule

@@ design/packet_port_filter_core.sv @@
// Flow: an accepted item is decoded; clear then sweeps all ports, install sweeps ports first
//   to last unless it sets nothing, and every item ends by loading the output register.
// Throughput: one item at a time. Install and clear sweep the flag memories one port per
//   cycle through their single write port.
// Reset: synchronous, active low. Afterwards a clearing pass zeroes all four tables with
//   o_ready low; configuration writes are taken during it.
module packet_port_filter_core #(
    parameter int PORT_BITS = ppf_pkg::PORT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_protocol,
    input  logic [5:0]  i_ip_header_len,
    input  logic [15:0] i_ip_total_len,
    input  logic [3:0]  i_tcp_data_offset,
    input  logic [15:0] i_port_a,
    input  logic [15:0] i_port_b,
    input  logic        i_sel_tcp,
    input  logic        i_sel_udp,
    input  logic        i_sel_src,
    input  logic        i_sel_dst,
    // result item channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_pass,
    output logic        o_is_verdict,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ppf_pkg::t_ctl w_ctl;
    ppf_pkg::t_sts w_sts;
    logic          r_filter_enable;
    logic          r_icmp_pass;
    logic          w_cfg_wr;

    // Config registers. paddr[2] picks the register; the low address bits are ignored.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
            r_icmp_pass     <= 1'b0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == ppf_pkg::REG_FILTER_ENABLE) begin
                r_filter_enable <= pwdata[0];
            end else begin
                r_icmp_pass <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == ppf_pkg::REG_ICMP_PASS) ? {31'd0, r_icmp_pass}
                                                         : {31'd0, r_filter_enable};

    // Controller: init sweep, decode, clear/install sweeps, result hand-off.
    ppf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    // Datapath: item registers, four flag memories, sweep counter, verdict logic.
    ppf_datapath #(.PORT_BITS(PORT_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_filter_enable   (r_filter_enable),
        .i_icmp_pass       (r_icmp_pass),
        .i_cmd             (i_cmd),
        .i_protocol        (i_protocol),
        .i_ip_header_len   (i_ip_header_len),
        .i_ip_total_len    (i_ip_total_len),
        .i_tcp_data_offset (i_tcp_data_offset),
        .i_port_a          (i_port_a),
        .i_port_b          (i_port_b),
        .i_sel_tcp         (i_sel_tcp),
        .i_sel_udp         (i_sel_udp),
        .i_sel_src         (i_sel_src),
        .i_sel_dst         (i_sel_dst),
        .o_pass            (o_pass),
        .o_is_verdict      (o_is_verdict)
    );

    // only one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another is in flight");

    // non-classify results never pass
    a_pass_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_verdict) |-> !o_pass)
        else $error("pass set on a non-classify result");

    // a loaded result is presented next cycle
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_out |=> o_valid)
        else $error("result loaded but not valid");

    // clear and install sweeps never overlap
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.clear_wr && w_ctl.fill_wr))
        else $error("clear and install sweep at once");

endmodule
